// ===== design/mi4_pkg.sv =====
// Shared types, widths and helper functions for the 4x4 matrix inverse core.
// No dependencies; imported by every module of the block.
package mi4_pkg;

    localparam int EL_W  = 32;   // element width
    localparam int Q_W   = 33;   // quotient bits kept before saturation
    localparam int COF_W = 128;  // cofactor accumulator, four 32-bit limbs
    localparam int DET_W = 136;  // determinant accumulator
    localparam int PR_W  = 66;   // 33 x 33 signed product

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_COF_INIT,
        ST_TRI,
        ST_LIMB,
        ST_DET_E,
        ST_DET_DONE,
        ST_OUT_PREP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    // Commands from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic       ld_x_mem;
        logic       ld_y_mem;
        logic       mul_en;
        logic       ld_src_pr;
        logic       ld_src_cof;
        logic       ld_limb;
        logic [1:0] limb_sel;
        logic       acc_en;
        logic [1:0] acc_sh;
        logic       acc_det;
        logic       acc_neg;
        logic       clr_cof;
        logic       clr_det;
    } mac_ctl_t;

    // i-th index of {0..3} with x left out
    function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] i);
        return (i < x) ? i : 2'(i + 2'd1);
    endfunction

    // column taken by row i in the t-th term of a 3x3 determinant
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] i);
        logic [5:0] p;
        begin
            unique case (t)
                3'd0:    p = {2'd2, 2'd1, 2'd0};
                3'd1:    p = {2'd1, 2'd2, 2'd0};
                3'd2:    p = {2'd2, 2'd0, 2'd1};
                3'd3:    p = {2'd0, 2'd2, 2'd1};
                3'd4:    p = {2'd1, 2'd0, 2'd2};
                3'd5:    p = {2'd0, 2'd1, 2'd2};
                default: p = {2'd2, 2'd1, 2'd0};
            endcase
            return p[2*i +: 2];
        end
    endfunction

    // odd permutations: terms 1, 2 and 5
    function automatic logic perm_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

    // saturate a magnitude with its sign to the signed 32-bit range
    function automatic logic [EL_W-1:0] sat32(input logic [Q_W-1:0] q, input logic big,
                                              input logic neg);
        if (!neg) begin
            return (big || q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[EL_W-1:0];
        end
        return (big || q > 33'h080000000) ? 32'h80000000 : 32'(32'd0 - q[EL_W-1:0]);
    endfunction

endpackage

// ===== design/mi4_store.sv =====
// Sixteen-word matrix store, one write and one registered read port.
// Depends on mi4_pkg.
module mi4_store
    import mi4_pkg::*;
(
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [3:0]      wr_addr,
    input  logic [EL_W-1:0] wr_data,
    input  logic [3:0]      rd_addr,
    output logic [EL_W-1:0] rd_data
);

    logic [EL_W-1:0] mem [16];
    logic [EL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/mi4_mac.sv =====
// Shared 33x33 multiplier with limb sequencing into cofactor and determinant
// accumulators. Depends on mi4_pkg.
module mi4_mac
    import mi4_pkg::*;
(
    input  logic                    aclk,
    input  mac_ctl_t                ctl,
    input  logic [EL_W-1:0]         mem_data,
    output logic signed [COF_W-1:0] cof,
    output logic signed [DET_W-1:0] det
);

    logic signed [Q_W-1:0]   mx_reg, my_reg;
    logic signed [PR_W-1:0]  pr_reg;
    logic signed [COF_W-1:0] src_reg;
    logic signed [COF_W-1:0] cof_reg;
    logic signed [DET_W-1:0] det_reg;

    logic signed [Q_W-1:0]   limb;
    logic signed [DET_W-1:0] pr_ext, term;

    always_comb begin
        unique case (ctl.limb_sel)
            2'd0: limb = {1'b0, src_reg[31:0]};
            2'd1: limb = {1'b0, src_reg[63:32]};
            2'd2: limb = {1'b0, src_reg[95:64]};
            2'd3: limb = {src_reg[127], src_reg[127:96]};
            default: limb = '0;
        endcase
        pr_ext = {{(DET_W-PR_W){pr_reg[PR_W-1]}}, pr_reg};
        term   = pr_ext <<< (32 * ctl.acc_sh);
        if (ctl.acc_neg) begin
            term = -term;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_x_mem) begin
            mx_reg <= {mem_data[EL_W-1], mem_data};
        end else if (ctl.ld_limb) begin
            mx_reg <= limb;
        end
        if (ctl.ld_y_mem) begin
            my_reg <= {mem_data[EL_W-1], mem_data};
        end
        if (ctl.mul_en) begin
            pr_reg <= mx_reg * my_reg;
        end
        if (ctl.ld_src_pr) begin
            src_reg <= {{(COF_W-64){pr_reg[63]}}, pr_reg[63:0]};
        end else if (ctl.ld_src_cof) begin
            src_reg <= cof_reg;
        end
        if (ctl.clr_cof) begin
            cof_reg <= '0;
        end else if (ctl.acc_en && !ctl.acc_det) begin
            cof_reg <= cof_reg + term[COF_W-1:0];
        end
        if (ctl.clr_det) begin
            det_reg <= '0;
        end else if (ctl.acc_en && ctl.acc_det) begin
            det_reg <= det_reg + term;
        end
    end

    assign cof = cof_reg;
    assign det = det_reg;

endmodule

// ===== design/mi4_div.sv =====
// Restoring divider: 33 quotient bits, one per cycle, with an overflow flag.
// Depends on mi4_pkg.
module mi4_div
    import mi4_pkg::*;
#(
    parameter int NUM_W = 160,
    parameter int DEN_W = 136
)(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo,
    output logic             big
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   lo_reg, quo_reg;
    logic [5:0]       cnt_reg;
    logic             run_reg, done_reg, big_reg;

    logic [CMP_W-1:0] num_hi;
    logic [DEN_W+1:0] trial;

    always_comb begin
        num_hi = CMP_W'(num[NUM_W-1:Q_W]);
        trial  = {1'b0, rem_reg, lo_reg[Q_W-1]} - {2'b00, den};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 6'(Q_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            big_reg <= num_hi >= CMP_W'(den);
            rem_reg <= num_hi[DEN_W-1:0];
            lo_reg  <= num[Q_W-1:0];
            quo_reg <= '0;
        end else if (run_reg) begin
            if (!trial[DEN_W+1]) begin
                rem_reg <= trial[DEN_W-1:0];
            end else begin
                rem_reg <= {rem_reg[DEN_W-2:0], lo_reg[Q_W-1]};
            end
            quo_reg <= {quo_reg[Q_W-2:0], ~trial[DEN_W+1]};
            lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign big  = big_reg;

endmodule

// ===== design/matrix_inverse_4x4_core.sv =====
// Top level of the 4x4 matrix inverse (adjugate over determinant).
// Depends on mi4_pkg, mi4_store, mi4_mac and mi4_div.
//
//  channel  dir  ports                                          word
//  s_       in   s_valid s_ready s_element                      one element
//  m_       out  m_valid m_ready m_inverse_element m_position   one inverse
//                m_determinant m_singular m_last                element
//
// The sixteen elements load first. Everything then runs through one 33x33
// multiplier: 6 triple products per cofactor, 4 cofactors and 4 limb MACs
// for the determinant, then per result a cofactor, a divide with its start
// and finish, and the prep and emit states. s_ready is high only while
// loading. A singular matrix skips the cofactors and divides. Reset is
// synchronous and drops any partial load; a stalled m_ready simply holds
// the sequencer.
module matrix_inverse_4x4_core
    import mi4_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [EL_W-1:0] s_element,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [EL_W-1:0] m_inverse_element,
    output logic [3:0]             m_position,
    output logic signed [EL_W-1:0] m_determinant,
    output logic                   m_singular,
    output logic                   m_last
);

    localparam int NUM_W = COF_W + 2 * FRACTION_BITS;

    state_t state_reg, state_next;
    logic [3:0] load_cnt_reg, load_cnt_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] term_reg, term_next;
    logic [1:0] idx_reg, idx_next;
    logic [3:0] pos_reg, pos_next;
    logic       mode_out_reg, mode_out_next;
    logic       lim_det_reg, lim_det_next;
    logic       lim_neg_reg, lim_neg_next;
    logic       sing_reg, sing_next;
    logic       dneg_reg, dneg_next;

    logic [DET_W-1:0] dmag_reg;
    logic [EL_W-1:0]  det_out_reg, res_reg;

    mac_ctl_t         ctl;
    logic [3:0]       rd_addr;
    logic [EL_W-1:0]  rd_data;
    logic signed [COF_W-1:0] cof;
    logic signed [DET_W-1:0] det;
    logic             div_start, div_done, div_big;
    logic [Q_W-1:0]   div_quo;
    logic [1:0]       row_c, col_c;
    logic [1:0]       fi;
    logic             accept;
    logic [COF_W-1:0] cmag;
    logic [NUM_W-1:0] num;
    logic [DET_W-1:0] dshift;

    assign accept = s_valid && s_ready;
    assign row_c  = mode_out_reg ? pos_reg[3:2] : 2'd0;
    assign col_c  = mode_out_reg ? pos_reg[1:0] : idx_reg;
    assign fi     = (phase_reg == 3'd0) ? 2'd0 : (phase_reg == 3'd1) ? 2'd1 : 2'd2;
    assign cmag   = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
    assign num    = NUM_W'(cmag) << (2 * FRACTION_BITS);
    assign dshift = dmag_reg >> (3 * FRACTION_BITS);

    mi4_store u_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (load_cnt_reg),
        .wr_data (s_element),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mi4_mac u_mac (
        .aclk     (aclk),
        .ctl      (ctl),
        .mem_data (rd_data),
        .cof      (cof),
        .det      (det)
    );

    mi4_div #(
        .NUM_W (NUM_W),
        .DEN_W (DET_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (dmag_reg),
        .done    (div_done),
        .quo     (div_quo),
        .big     (div_big)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            phase_reg    <= '0;
            term_reg     <= '0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            mode_out_reg <= 1'b0;
            lim_det_reg  <= 1'b0;
            lim_neg_reg  <= 1'b0;
            sing_reg     <= 1'b0;
            dneg_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            phase_reg    <= phase_next;
            term_reg     <= term_next;
            idx_reg      <= idx_next;
            pos_reg      <= pos_next;
            mode_out_reg <= mode_out_next;
            lim_det_reg  <= lim_det_next;
            lim_neg_reg  <= lim_neg_next;
            sing_reg     <= sing_next;
            dneg_reg     <= dneg_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DET_DONE) begin
            dmag_reg <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
        end
        if (state_reg == ST_OUT_PREP) begin
            det_out_reg <= sat32(dshift[Q_W-1:0], |dshift[DET_W-1:Q_W], dneg_reg);
            if (sing_reg) begin
                res_reg <= (pos_reg[3:2] == pos_reg[1:0]) ?
                           (EL_W'(1) << FRACTION_BITS) : '0;
            end
        end
        if (state_reg == ST_DIV_WAIT && div_done) begin
            res_reg <= sat32(div_quo, div_big, cof[COF_W-1] ^ dneg_reg);
        end
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        phase_next    = phase_reg;
        term_next     = term_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        mode_out_next = mode_out_reg;
        lim_det_next  = lim_det_reg;
        lim_neg_next  = lim_neg_reg;
        sing_next     = sing_reg;
        dneg_next     = dneg_reg;
        ctl           = '0;
        rd_addr       = {skip_idx(col_c, perm_col(term_reg, fi)), skip_idx(row_c, fi)};
        div_start     = 1'b0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (accept) begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15) begin
                        ctl.clr_det   = 1'b1;
                        idx_next      = '0;
                        mode_out_next = 1'b0;
                        state_next    = ST_COF_INIT;
                    end
                end
            end
            ST_COF_INIT: begin
                ctl.clr_cof = 1'b1;
                term_next   = '0;
                phase_next  = '0;
                state_next  = ST_TRI;
            end
            ST_TRI: begin
                // fetch three factors, multiply the first two
                phase_next = phase_reg + 3'd1;
                unique case (phase_reg)
                    3'd1: ctl.ld_x_mem = 1'b1;
                    3'd2: ctl.ld_y_mem = 1'b1;
                    3'd3: begin
                        ctl.ld_y_mem = 1'b1;
                        ctl.mul_en   = 1'b1;
                    end
                    3'd4: begin
                        ctl.ld_src_pr = 1'b1;
                        lim_det_next  = 1'b0;
                        lim_neg_next  = perm_neg(term_reg) ^ row_c[0] ^ col_c[0];
                        phase_next    = '0;
                        state_next    = ST_LIMB;
                    end
                    default: ;
                endcase
            end
            ST_LIMB: begin
                // src times y, one limb a cycle, two-stage pipe
                phase_next   = phase_reg + 3'd1;
                ctl.ld_limb  = phase_reg <= 3'd3;
                ctl.limb_sel = phase_reg[1:0];
                ctl.mul_en   = (phase_reg >= 3'd1) && (phase_reg <= 3'd4);
                ctl.acc_en   = phase_reg >= 3'd2;
                ctl.acc_sh   = 2'(phase_reg - 3'd2);
                ctl.acc_det  = lim_det_reg;
                ctl.acc_neg  = lim_neg_reg;
                if (phase_reg == 3'd5) begin
                    phase_next = '0;
                    if (!lim_det_reg) begin
                        if (term_reg == 3'd5) begin
                            state_next = mode_out_reg ? ST_DIV_START : ST_DET_E;
                        end else begin
                            term_next  = term_reg + 3'd1;
                            state_next = ST_TRI;
                        end
                    end else if (idx_reg == 2'd3) begin
                        state_next = ST_DET_DONE;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_COF_INIT;
                    end
                end
            end
            ST_DET_E: begin
                rd_addr    = {idx_reg, 2'd0};
                phase_next = phase_reg + 3'd1;
                if (phase_reg != 3'd0) begin
                    ctl.ld_y_mem   = 1'b1;
                    ctl.ld_src_cof = 1'b1;
                    lim_det_next   = 1'b1;
                    lim_neg_next   = 1'b0;
                    phase_next     = '0;
                    state_next     = ST_LIMB;
                end
            end
            ST_DET_DONE: begin
                sing_next     = det == '0;
                dneg_next     = det[DET_W-1];
                pos_next      = '0;
                mode_out_next = 1'b1;
                state_next    = ST_OUT_PREP;
            end
            ST_OUT_PREP: begin
                state_next = sing_reg ? ST_EMIT : ST_COF_INIT;
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    pos_next = pos_reg + 4'd1;
                    state_next = (pos_reg == 4'd15) ? ST_LOAD : ST_OUT_PREP;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign m_inverse_element = res_reg;
    assign m_position        = pos_reg;
    assign m_determinant     = sing_reg ? '0 : det_out_reg;
    assign m_singular        = sing_reg;
    assign m_last            = pos_reg == 4'd15;

endmodule

// ===== tb/sv/mi4_checker.sv =====
// Scoreboard for the 4x4 matrix inverse: watches both channels, predicts
// each inverse word exactly and compares. Depends on mi4_pkg (EL_W).
`timescale 1ns / 100ps
module mi4_checker
    import mi4_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic signed [EL_W-1:0] s_element,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic signed [EL_W-1:0] m_inverse_element,
    input  logic [3:0]             m_position,
    input  logic signed [EL_W-1:0] m_determinant,
    input  logic                   m_singular,
    input  logic                   m_last,
    output int                     fail_count,
    output int                     pending
);

    localparam int FB = 16;

    typedef logic signed [255:0] big_t;

    typedef struct {
        logic signed [EL_W-1:0] inv;
        logic [3:0]             pos;
        logic signed [EL_W-1:0] det;
        logic                   sing;
        logic                   last;
    } inv_word_t;

    logic signed [EL_W-1:0] loaded [16];
    logic [3:0]             load_idx;
    inv_word_t              inverse_q [$];

    // element at (row, col), column-major store
    function automatic big_t at(input logic signed [EL_W-1:0] mt [16], input int r,
                                input int c);
        big_t v;
        v = mt[c*4 + r];
        return v;
    endfunction

    // signed cofactor of (row, col)
    function automatic big_t cofactor_of(input logic signed [EL_W-1:0] mt [16],
                                         input int row, input int col);
        int   rs [3];
        int   cs [3];
        int   n;
        big_t d;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != row) begin rs[n] = i; n++; end
        n = 0;
        for (int i = 0; i < 4; i++) if (i != col) begin cs[n] = i; n++; end
        d = at(mt, rs[0], cs[0]) * (at(mt, rs[1], cs[1]) * at(mt, rs[2], cs[2])
                                  - at(mt, rs[1], cs[2]) * at(mt, rs[2], cs[1]))
          - at(mt, rs[0], cs[1]) * (at(mt, rs[1], cs[0]) * at(mt, rs[2], cs[2])
                                  - at(mt, rs[1], cs[2]) * at(mt, rs[2], cs[0]))
          + at(mt, rs[0], cs[2]) * (at(mt, rs[1], cs[0]) * at(mt, rs[2], cs[1])
                                  - at(mt, rs[1], cs[1]) * at(mt, rs[2], cs[0]));
        return ((row + col) % 2 == 1) ? -d : d;
    endfunction

    function automatic logic [EL_W-1:0] clamp32(input big_t mag, input logic neg);
        if (!neg) return (mag > big_t'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : mag[31:0];
        return (mag > big_t'(33'h080000000)) ? 32'h80000000 : 32'(32'd0 - mag[31:0]);
    endfunction

    task automatic predict_inverse(input logic signed [EL_W-1:0] mt [16]);
        big_t      cof [16];
        big_t      det, dmag, cmag;
        logic      dneg, sing;
        inv_word_t w;
        logic [EL_W-1:0] det_out;
        for (int p = 0; p < 16; p++) cof[p] = cofactor_of(mt, p % 4, p / 4);
        det = 0;
        for (int i = 0; i < 4; i++) det += at(mt, 0, i) * cof[i*4];
        sing    = (det == 0);
        dneg    = det < 0;
        dmag    = dneg ? -det : det;
        det_out = clamp32(dmag >> (3*FB), dneg);
        for (int p = 0; p < 16; p++) begin
            int col, row;
            col = p / 4;
            row = p % 4;
            if (sing) begin
                w.inv = (col == row) ? (32'sd1 <<< FB) : 32'sd0;
            end else begin
                // adjugate is the transposed cofactor matrix
                cmag  = cof[row*4 + col];
                w.inv = clamp32(((cmag < 0 ? -cmag : cmag) << (2*FB)) / dmag,
                                (cmag < 0) != dneg);
            end
            w.pos  = 4'(p);
            w.det  = sing ? 32'sd0 : det_out;
            w.sing = sing;
            w.last = (p == 15);
            inverse_q.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            load_idx   <= 4'd0;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) begin
                logic signed [EL_W-1:0] mt [16];
                mt = loaded;
                mt[load_idx] = s_element;
                loaded[load_idx] <= s_element;
                load_idx <= load_idx + 4'd1;
                if (load_idx == 4'd15) predict_inverse(mt);
            end
            if (m_valid && m_ready) begin
                inv_word_t e;
                int errs;
                errs = 0;
                if (inverse_q.size() == 0) begin
                    $error("unexpected inverse word at position %0d", m_position);
                    errs = 1;
                end else begin
                    e = inverse_q.pop_front();
                    if (m_inverse_element !== e.inv) begin
                        $error("inverse_element exp %0d got %0d", e.inv, m_inverse_element);
                        errs++;
                    end
                    if (m_position !== e.pos) begin
                        $error("position exp %0d got %0d", e.pos, m_position);
                        errs++;
                    end
                    if (m_determinant !== e.det) begin
                        $error("determinant exp %0d got %0d", e.det, m_determinant);
                        errs++;
                    end
                    if (m_singular !== e.sing) begin
                        $error("singular exp %0b got %0b", e.sing, m_singular);
                        errs++;
                    end
                    if (m_last !== e.last) begin
                        $error("last exp %0b got %0b", e.last, m_last);
                        errs++;
                    end
                end
                if (errs != 0) fail_count <= fail_count + 1;
            end
            pending <= inverse_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the matrix inverse testbench: clock, reset, element stimulus and
// result back-pressure. Depends on mi4_pkg, mi4_checker and the core.
`timescale 1ns / 100ps
module testbench;
    import mi4_pkg::*;

    localparam int LIMIT = 400000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic signed [EL_W-1:0] s_element;
    logic                   m_valid;
    logic                   m_ready;
    logic signed [EL_W-1:0] m_inverse_element;
    logic [3:0]             m_position;
    logic signed [EL_W-1:0] m_determinant;
    logic                   m_singular;
    logic                   m_last;
    int                     fail_count;
    int                     pending;
    int                     cycles;
    logic signed [EL_W-1:0] mat [16];

    matrix_inverse_4x4_core dut (.*);

    mi4_checker scoreboard (.*);

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // offer one element, with an optional idle gap first
    task automatic send_word(input logic signed [EL_W-1:0] x);
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_element <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_matrix();
        for (int i = 0; i < 16; i++) send_word(mat[i]);
    endtask

    task automatic random_matrix(input int kind);
        for (int i = 0; i < 16; i++) begin
            unique case (kind)
                0: mat[i] = $urandom;
                1: mat[i] = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
                2: mat[i] = $signed($urandom_range(0, 64)) - 32;
                default: mat[i] = ((i % 5) == 0) ? ($urandom_range(1, 3) << 16)
                                                  : $signed($urandom_range(0, 510)) - 255;
            endcase
        end
        // copy a column now and then to force a singular matrix
        if ($urandom_range(0, 4) == 0)
            for (int r = 0; r < 4; r++) mat[12 + r] = mat[4 + r];
    endtask

    // receiver back-pressure; one long hold-off while the sender keeps going
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        for (int stretch = 0; ; stretch++) begin
            if (stretch == 6) begin
                m_ready <= 1'b0;
                repeat (5000) @(posedge aclk);
            end else if (stretch % 3 == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(20, 200)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(10, 100)) begin
                    m_ready <= ($urandom_range(0, 2) != 0);
                    @(posedge aclk);
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_element = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes on the diagonal: tiny inverse terms and saturation
        for (int i = 0; i < 16; i++) mat[i] = 0;
        mat[0] = 32'sh80000000; mat[5] = 32'sh7FFFFFFF; mat[10] = 1; mat[15] = -1;
        send_matrix();
        // all maximum: rank one, singular
        for (int i = 0; i < 16; i++) mat[i] = 32'sh7FFFFFFF;
        send_matrix();
        // tiny nonzero determinant, reported as zero but still inverted
        for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'sd1 : 32'sd0;
        send_matrix();

        // sender waits for the results of the first three matrices before going on
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);

        for (int m = 0; m < 12; m++) begin
            random_matrix($urandom_range(0, 3));
            send_matrix();
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
